[rtl/indexed_min_heap_key_update_core_defines.svh]
// Assertion macros shared by the indexed min-heap key update core.
`ifndef INDEXED_MIN_HEAP_KEY_UPDATE_CORE_DEFINES_SVH
`define INDEXED_MIN_HEAP_KEY_UPDATE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define IMHKU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define IMHKU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMHKU_ASSERT_IMPL(label, ante, cons, msg)
`define IMHKU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/imhku_pkg.sv]
// Shared constants, codes and control types of the indexed min-heap key update core.
package imhku_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int KEY_BITS_DEF = 32;

  localparam int ACT_W  = 2;
  localparam int ID_W   = 10;
  localparam int CNT_W  = 11;
  localparam int KEY_W  = 32;
  localparam int SWAP_W = 4;

  localparam logic [SWAP_W-1:0] SWAP_MAX = 4'hF;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_UP    = 2'd1,
    ACT_DOWN  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  // From the top level to the sequencer.
  typedef struct packed {
    logic start;
    logic res_free;
  } ctl_t;

  // From the sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } sts_t;

endpackage

[rtl/imhku_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module imhku_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/imhku_ctrl.sv]
// Sequencer that walks the heap through the slot memory and the node memory.
module imhku_ctrl #(
  parameter int NODES    = imhku_pkg::NODES_DEF,
  parameter int KEY_BITS = imhku_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  imhku_pkg::ctl_t                   ctl,
  output imhku_pkg::sts_t                   sts,
  input  imhku_pkg::act_t                   item_act,
  input  logic [$clog2(NODES)-1:0]          item_node,
  input  logic [$clog2(NODES)-1:0]          item_slot,
  input  logic signed [KEY_BITS-1:0]        item_key,
  input  logic [$clog2(NODES+1)-1:0]        item_count,
  output logic [$clog2(NODES)-1:0]          res_slot,
  output logic [$clog2(NODES)-1:0]          res_top,
  output logic signed [KEY_BITS-1:0]        res_key,
  output logic [imhku_pkg::SWAP_W-1:0]      res_swaps,
  output logic                              heap_we,
  output logic [$clog2(NODES)-1:0]          heap_waddr,
  output logic [$clog2(NODES)-1:0]          heap_wdata,
  output logic [$clog2(NODES)-1:0]          heap_raddr,
  input  logic [$clog2(NODES)-1:0]          heap_rdata,
  output logic                              nm_we,
  output logic [$clog2(NODES)-1:0]          nm_waddr,
  output logic [$clog2(NODES)+KEY_BITS-1:0] nm_wdata,
  output logic [$clog2(NODES)-1:0]          nm_raddr,
  input  logic [$clog2(NODES)+KEY_BITS-1:0] nm_rdata
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int XW = IW + 2;
  localparam int EW = IW + KEY_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_GET_NS,
    S_GET_HV,
    S_STEP,
    S_RD_N1,
    S_RD_K1,
    S_RD_N2,
    S_RD_K2,
    S_DECIDE,
    S_FINAL,
    S_TOP0,
    S_TOP1,
    S_TOP2,
    S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  imhku_pkg::act_t             act_r, act_nxt;
  logic [IW-1:0]               node_r, node_nxt;
  logic [IW-1:0]               slot_r, slot_nxt;
  logic signed [KEY_BITS-1:0]  key_r, key_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [IW-1:0]               h_r, h_nxt;
  logic [IW-1:0]               ns_r, ns_nxt;
  logic [IW-1:0]               hv_r, hv_nxt;
  logic [IW-1:0]               pos_r, pos_nxt;
  logic                        has2_r, has2_nxt;
  logic [IW-1:0]               n1_r, n1_nxt;
  logic [IW-1:0]               n2_r, n2_nxt;
  logic [IW-1:0]               e1_slot_r, e1_slot_nxt;
  logic [IW-1:0]               e2_slot_r, e2_slot_nxt;
  logic signed [KEY_BITS-1:0]  e1_key_r, e1_key_nxt;
  logic signed [KEY_BITS-1:0]  e2_key_r, e2_key_nxt;
  logic [imhku_pkg::SWAP_W-1:0] swaps_r, swaps_nxt;
  logic [IW-1:0]               top_r, top_nxt;
  logic signed [KEY_BITS-1:0]  topkey_r, topkey_nxt;

  // The node being moved keeps its entry in registers during a sift, so any
  // read of that node's entry is served from them.
  logic [IW-1:0]              fw_node;
  logic                       fw_hit;
  logic [IW-1:0]              fw_slot;
  logic signed [KEY_BITS-1:0] fw_key;

  logic [XW-1:0]              c1_x;
  logic [XW-1:0]              c2_x;
  logic [XW-1:0]              cnt_x;

  logic                       lt1;
  logic                       lt2k;
  logic                       lt21;
  logic                       sel2;
  logic                       go;
  logic [IW-1:0]              x_other;
  logic [IW-1:0]              x_slot;
  logic signed [KEY_BITS-1:0] x_key;
  logic [IW-1:0]              x_pos;

  assign fw_node = (state_r == S_RD_K2) ? n2_r : n1_r;
  assign fw_hit  = (fw_node == node_r);
  assign fw_slot = fw_hit ? ns_r : nm_rdata[EW-1:KEY_BITS];
  assign fw_key  = fw_hit ? key_r : signed'(nm_rdata[KEY_BITS-1:0]);

  assign c1_x  = {1'b0, h_r, 1'b1};
  assign c2_x  = c1_x + XW'(1);
  assign cnt_x = XW'(count_r);

  // Sift up compares only the parent; sift down picks between up to two children.
  assign lt1  = (e1_key_r < key_r);
  assign lt2k = has2_r && (e2_key_r < key_r);
  assign lt21 = has2_r && (e2_key_r < e1_key_r);
  assign sel2 = (act_r == imhku_pkg::ACT_DOWN) && (lt1 ? lt21 : lt2k);
  assign go   = (act_r == imhku_pkg::ACT_UP) ? (e1_key_r > key_r) : (lt1 || lt2k);

  assign x_other = sel2 ? n2_r : n1_r;
  assign x_slot  = sel2 ? e2_slot_r : e1_slot_r;
  assign x_key   = sel2 ? e2_key_r : e1_key_r;
  assign x_pos   = sel2 ? (pos_r + IW'(1)) : pos_r;

  assign res_slot  = (act_r == imhku_pkg::ACT_WRITE) ? slot_r : ns_r;
  assign res_top   = top_r;
  assign res_key   = topkey_r;
  assign res_swaps = swaps_r;

  assign sts.busy = (state_r != S_IDLE);
  assign sts.done = (state_r == S_DONE) && ctl.res_free;

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    node_nxt    = node_r;
    slot_nxt    = slot_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    h_nxt       = h_r;
    ns_nxt      = ns_r;
    hv_nxt      = hv_r;
    pos_nxt     = pos_r;
    has2_nxt    = has2_r;
    n1_nxt      = n1_r;
    n2_nxt      = n2_r;
    e1_slot_nxt = e1_slot_r;
    e2_slot_nxt = e2_slot_r;
    e1_key_nxt  = e1_key_r;
    e2_key_nxt  = e2_key_r;
    swaps_nxt   = swaps_r;
    top_nxt     = top_r;
    topkey_nxt  = topkey_r;
    heap_we     = 1'b0;
    heap_waddr  = slot_r;
    heap_wdata  = node_r;
    heap_raddr  = '0;
    nm_we       = 1'b0;
    nm_waddr    = node_r;
    nm_wdata    = {slot_r, key_r};
    nm_raddr    = node_r;

    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          act_nxt   = item_act;
          node_nxt  = item_node;
          slot_nxt  = item_slot;
          key_nxt   = item_key;
          count_nxt = item_count;
          swaps_nxt = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (act_r == imhku_pkg::ACT_WRITE) begin
          heap_we   = 1'b1;
          nm_we     = 1'b1;
          state_nxt = S_TOP0;
        end else begin
          state_nxt = S_GET_NS;
        end
      end
      S_GET_NS: begin
        ns_nxt     = nm_rdata[EW-1:KEY_BITS];
        h_nxt      = nm_rdata[EW-1:KEY_BITS];
        heap_raddr = nm_rdata[EW-1:KEY_BITS];
        if (act_r == imhku_pkg::ACT_NONE) begin
          state_nxt = S_TOP0;
        end else begin
          state_nxt = S_GET_HV;
        end
      end
      S_GET_HV: begin
        hv_nxt    = heap_rdata;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        case (act_r)
          imhku_pkg::ACT_UP: begin
            pos_nxt    = (h_r - IW'(1)) >> 1;
            heap_raddr = (h_r - IW'(1)) >> 1;
            state_nxt  = (h_r == '0) ? S_FINAL : S_RD_N1;
          end
          imhku_pkg::ACT_DOWN: begin
            pos_nxt    = c1_x[IW-1:0];
            has2_nxt   = (c2_x < cnt_x);
            heap_raddr = c1_x[IW-1:0];
            state_nxt  = (c1_x >= cnt_x) ? S_FINAL : S_RD_N1;
          end
          default: begin
            state_nxt = S_FINAL;
          end
        endcase
      end
      S_RD_N1: begin
        n1_nxt    = heap_rdata;
        nm_raddr  = heap_rdata;
        state_nxt = S_RD_K1;
      end
      S_RD_K1: begin
        e1_slot_nxt = fw_slot;
        e1_key_nxt  = fw_key;
        heap_raddr  = pos_r + IW'(1);
        if ((act_r == imhku_pkg::ACT_DOWN) && has2_r) begin
          state_nxt = S_RD_N2;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_RD_N2: begin
        n2_nxt    = heap_rdata;
        nm_raddr  = heap_rdata;
        state_nxt = S_RD_K2;
      end
      S_RD_K2: begin
        e2_slot_nxt = fw_slot;
        e2_key_nxt  = fw_key;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        if (go) begin
          // The slot at h gets the other node; the moving node's slot entry
          // and its heap position are written back once the sift ends.
          heap_we    = 1'b1;
          heap_waddr = h_r;
          heap_wdata = x_other;
          nm_we      = (x_other != node_r);
          nm_waddr   = x_other;
          nm_wdata   = {ns_r, x_key};
          ns_nxt     = x_slot;
          h_nxt      = x_pos;
          if (swaps_r != imhku_pkg::SWAP_MAX) begin
            swaps_nxt = swaps_r + imhku_pkg::SWAP_W'(1);
          end
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        heap_we    = 1'b1;
        heap_waddr = h_r;
        heap_wdata = hv_r;
        nm_we      = 1'b1;
        nm_waddr   = node_r;
        nm_wdata   = {ns_r, key_r};
        state_nxt  = S_TOP0;
      end
      S_TOP0: begin
        heap_raddr = '0;
        state_nxt  = S_TOP1;
      end
      S_TOP1: begin
        top_nxt   = heap_rdata;
        nm_raddr  = heap_rdata;
        state_nxt = S_TOP2;
      end
      S_TOP2: begin
        topkey_nxt = signed'(nm_rdata[KEY_BITS-1:0]);
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (ctl.res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    act_r     <= act_nxt;
    node_r    <= node_nxt;
    slot_r    <= slot_nxt;
    key_r     <= key_nxt;
    count_r   <= count_nxt;
    h_r       <= h_nxt;
    ns_r      <= ns_nxt;
    hv_r      <= hv_nxt;
    pos_r     <= pos_nxt;
    has2_r    <= has2_nxt;
    n1_r      <= n1_nxt;
    n2_r      <= n2_nxt;
    e1_slot_r <= e1_slot_nxt;
    e2_slot_r <= e2_slot_nxt;
    e1_key_r  <= e1_key_nxt;
    e2_key_r  <= e2_key_nxt;
    swaps_r   <= swaps_nxt;
    top_r     <= top_nxt;
    topkey_r  <= topkey_nxt;
  end

endmodule

[rtl/indexed_min_heap_key_update_core.sv]
// Top level of the indexed min-heap key update core: ports, memories and result register.
//
//   channel   ports                                                 handshake
//   input     in_action in_node_id in_slot in_new_key in_heap_count in_valid / in_stall
//   result    out_final_slot out_top_node out_top_key out_swap_count out_valid / out_stall
//
// One item is worked at a time; the slot memory and the node memory each have one
// read port, and every lookup is a registered read. A write entry writes both
// memories and then reads the top of the heap. A sift up reads the parent for each
// swap, a sift down the first child and, when it exists, the second child.
// Reset clears only control state; memory contents stay unknown until written.
// A new item is taken while the previous result still waits under out_stall.
`include "indexed_min_heap_key_update_core_defines.svh"
module indexed_min_heap_key_update_core #(
  parameter int NODES    = imhku_pkg::NODES_DEF,
  parameter int KEY_BITS = imhku_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [imhku_pkg::ACT_W-1:0]         in_action,
  input  logic [imhku_pkg::ID_W-1:0]          in_node_id,
  input  logic [imhku_pkg::ID_W-1:0]          in_slot,
  input  logic signed [imhku_pkg::KEY_W-1:0]  in_new_key,
  input  logic [imhku_pkg::CNT_W-1:0]         in_heap_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [imhku_pkg::ID_W-1:0]          out_final_slot,
  output logic [imhku_pkg::ID_W-1:0]          out_top_node,
  output logic signed [imhku_pkg::KEY_W-1:0]  out_top_key,
  output logic [imhku_pkg::SWAP_W-1:0]        out_swap_count
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int EW = IW + KEY_BITS;

  imhku_pkg::ctl_t ctl;
  imhku_pkg::sts_t sts;

  logic [IW-1:0]                item_node;
  logic [IW-1:0]                item_slot;
  logic signed [KEY_BITS-1:0]   item_key;
  logic [CW-1:0]                item_count;
  logic signed [63:0]           key_ext;
  logic [17:0]                  cnt_ext;
  logic [17:0]                  cnt_clamp;

  logic [IW-1:0]                res_slot;
  logic [IW-1:0]                res_top;
  logic signed [KEY_BITS-1:0]   res_key;
  logic [imhku_pkg::SWAP_W-1:0] res_swaps;
  logic [31:0]                  slot_ext;
  logic [31:0]                  top_ext;
  logic signed [63:0]           res_key_ext;

  logic                         heap_we;
  logic [IW-1:0]                heap_waddr;
  logic [IW-1:0]                heap_wdata;
  logic [IW-1:0]                heap_raddr;
  logic [IW-1:0]                heap_rdata;
  logic                         nm_we;
  logic [IW-1:0]                nm_waddr;
  logic [EW-1:0]                nm_wdata;
  logic [IW-1:0]                nm_raddr;
  logic [EW-1:0]                nm_rdata;

  logic                                out_valid_r;
  logic [imhku_pkg::ID_W-1:0]          out_final_slot_r;
  logic [imhku_pkg::ID_W-1:0]          out_top_node_r;
  logic signed [imhku_pkg::KEY_W-1:0]  out_top_key_r;
  logic [imhku_pkg::SWAP_W-1:0]        out_swap_count_r;

  // Reduces a 10-bit id modulo NODES by conditional subtraction of shifted
  // copies of NODES; steps whose shifted value exceeds the field drop out.
  function automatic logic [IW-1:0] idx_reduce(input logic [imhku_pkg::ID_W-1:0] v);
    logic [17:0] r;
    r = 18'(v);
    for (int k = imhku_pkg::ID_W - 1; k >= 0; k--) begin
      if ((NODES << k) < (1 << imhku_pkg::ID_W)) begin
        if (r >= 18'(NODES << k)) begin
          r = r - 18'(NODES << k);
        end
      end
    end
    return r[IW-1:0];
  endfunction

  assign in_stall     = sts.busy;
  assign ctl.start    = in_valid && !in_stall;
  assign ctl.res_free = !out_valid_r || !out_stall;

  assign item_node  = idx_reduce(in_node_id);
  assign item_slot  = idx_reduce(in_slot);
  assign key_ext    = 64'(in_new_key);
  assign item_key   = signed'(key_ext[KEY_BITS-1:0]);
  assign cnt_ext    = 18'(in_heap_count);
  assign cnt_clamp  = (cnt_ext > 18'(NODES)) ? 18'(NODES) : cnt_ext;
  assign item_count = cnt_clamp[CW-1:0];

  imhku_ram #(
    .WIDTH (IW),
    .DEPTH (NODES)
  ) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  // Per-node entry: slot in the upper bits, key in the lower bits.
  imhku_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  imhku_ctrl #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .item_act   (imhku_pkg::act_t'(in_action)),
    .item_node  (item_node),
    .item_slot  (item_slot),
    .item_key   (item_key),
    .item_count (item_count),
    .res_slot   (res_slot),
    .res_top    (res_top),
    .res_key    (res_key),
    .res_swaps  (res_swaps),
    .heap_we    (heap_we),
    .heap_waddr (heap_waddr),
    .heap_wdata (heap_wdata),
    .heap_raddr (heap_raddr),
    .heap_rdata (heap_rdata),
    .nm_we      (nm_we),
    .nm_waddr   (nm_waddr),
    .nm_wdata   (nm_wdata),
    .nm_raddr   (nm_raddr),
    .nm_rdata   (nm_rdata)
  );

  assign slot_ext    = 32'(res_slot);
  assign top_ext     = 32'(res_top);
  assign res_key_ext = 64'(res_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (sts.done) begin
      out_final_slot_r <= slot_ext[imhku_pkg::ID_W-1:0];
      out_top_node_r   <= top_ext[imhku_pkg::ID_W-1:0];
      out_top_key_r    <= signed'(res_key_ext[imhku_pkg::KEY_W-1:0]);
      out_swap_count_r <= res_swaps;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_final_slot = out_final_slot_r;
  assign out_top_node   = out_top_node_r;
  assign out_top_key    = out_top_key_r;
  assign out_swap_count = out_swap_count_r;

  `IMHKU_ASSERT_IMPL(a_done_has_room, sts.done, !out_valid_r || !out_stall, "result overwrites a waiting one")
  `IMHKU_ASSERT_NEXT(a_start_goes_busy, ctl.start, sts.busy, "accepted item did not start the sequencer")
  `IMHKU_ASSERT_NEXT(a_done_gives_result, sts.done, !sts.busy && out_valid_r, "finished item left no result")

endmodule
